[design/mcg_pkg.sv]
package mcg_pkg;

  // Field widths of the request and result channels.
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 6;
  localparam int OUT_BITS    = 14;
  localparam int MAX_RADIUS  = 63;

  // Loop state widths, sized for a radius of at most MAX_RADIUS.
  localparam int OFS_X_BITS = 8;
  localparam int OFS_Y_BITS = 7;
  localparam int STEP_BITS  = 8;
  localparam int DEC_BITS   = 10;
  localparam int DIAM_BITS  = RADIUS_BITS + 1;

  // Request queue between the front and the back.
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;
  localparam int Q_CNT_BITS = 2;

  // One classified circle job, ready for the tracing loop.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [DIAM_BITS-1:0]  diam;
    logic [OFS_X_BITS-1:0] ox0;
    logic [DEC_BITS-1:0]   dec0;
  } job_t;

endpackage

[design/mcg_front.sv]
module mcg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcg_pkg::COORD_BITS-1:0]  in_centre_x,
  input  logic [mcg_pkg::COORD_BITS-1:0]  in_centre_y,
  input  logic [mcg_pkg::RADIUS_BITS-1:0] in_radius,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mcg_pkg::job_t                 push_data
);

  logic                           hold_valid_r;
  logic                           hold_valid_nxt;
  mcg_pkg::job_t                  job_r;
  mcg_pkg::job_t                  job_nxt;
  logic                           accept;
  logic [mcg_pkg::RADIUS_BITS-1:0] rad_sat;

  assign in_ready   = !hold_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = job_r;

  always_comb begin
    rad_sat = in_radius;
    if (in_radius > mcg_pkg::RADIUS_BITS'(mcg_pkg::MAX_RADIUS)) begin
      rad_sat = mcg_pkg::RADIUS_BITS'(mcg_pkg::MAX_RADIUS);
    end
    job_nxt.cx   = in_centre_x;
    job_nxt.cy   = in_centre_y;
    job_nxt.diam = {rad_sat, 1'b0};
    job_nxt.ox0  = mcg_pkg::OFS_X_BITS'(rad_sat) - mcg_pkg::OFS_X_BITS'(1);
    job_nxt.dec0 = mcg_pkg::DEC_BITS'(1) - mcg_pkg::DEC_BITS'({rad_sat, 1'b0});

    hold_valid_nxt = hold_valid_r;
    if (hold_valid_r && push_ready) begin
      hold_valid_nxt = 1'b0;
    end
    // A zero radius traces nothing, so it is taken and dropped here.
    if (accept) begin
      hold_valid_nxt = (rad_sat != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  a_no_zero_job: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> (job_r.diam != '0))
    else $error("front holds a job with zero radius");

endmodule

[design/mcg_queue.sv]
module mcg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mcg_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mcg_pkg::job_t pop_data
);

  mcg_pkg::job_t                  slot_r [mcg_pkg::Q_DEPTH];
  logic [mcg_pkg::Q_PTR_BITS-1:0] wr_ptr_r;
  logic [mcg_pkg::Q_PTR_BITS-1:0] wr_ptr_nxt;
  logic [mcg_pkg::Q_PTR_BITS-1:0] rd_ptr_r;
  logic [mcg_pkg::Q_PTR_BITS-1:0] rd_ptr_nxt;
  logic [mcg_pkg::Q_CNT_BITS-1:0] cnt_r;
  logic [mcg_pkg::Q_CNT_BITS-1:0] cnt_nxt;
  logic                           push;
  logic                           pop;

  assign push_ready = (cnt_r != mcg_pkg::Q_CNT_BITS'(mcg_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mcg_pkg::Q_CNT_BITS'(mcg_pkg::Q_DEPTH))
    else $error("queue occupancy above its depth");

endmodule

[design/mcg_back.sv]
module mcg_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  mcg_pkg::job_t                      pop_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_x_right,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_x_left,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_y_down,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_y_up,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_x_right_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_x_left_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_y_down_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0] out_y_up_swapped,
  output logic                               out_last
);

  localparam int OB = mcg_pkg::OUT_BITS;

  // Loop state of the circle being traced.
  logic                              busy_r, busy_nxt;
  logic [mcg_pkg::COORD_BITS-1:0]    cx_r, cy_r;
  logic [mcg_pkg::DIAM_BITS-1:0]     diam_r;
  logic signed [mcg_pkg::OFS_X_BITS-1:0] ox_r, ox_nxt;
  logic [mcg_pkg::OFS_Y_BITS-1:0]    oy_r, oy_nxt;
  logic [mcg_pkg::STEP_BITS-1:0]     sx_r, sx_nxt;
  logic [mcg_pkg::STEP_BITS-1:0]     sy_r, sy_nxt;
  logic signed [mcg_pkg::DEC_BITS-1:0] dec_r, dec_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic signed [OB-1:0] xr_r, xl_r, yd_r, yu_r, xrs_r, xls_r, yds_r, yus_r;
  logic                last_r;

  logic                  adv;
  logic                  step;
  logic                  load;
  logic                  dec_le;
  logic                  dec1_gt;
  logic                  last_nxt;
  logic signed [mcg_pkg::DEC_BITS-1:0] dec1;
  logic signed [OB-1:0]  cx_e, cy_e, ox_e, oy_e;

  assign adv       = !out_valid_r || out_ready;
  assign step      = busy_r && adv;
  assign pop_ready = !busy_r;
  assign load      = pop_valid && !busy_r;

  assign cx_e = signed'(OB'(cx_r));
  assign cy_e = signed'(OB'(cy_r));
  assign ox_e = OB'(ox_r);
  assign oy_e = signed'(OB'(oy_r));

  always_comb begin
    dec_le = dec_r[mcg_pkg::DEC_BITS-1] || (dec_r == '0);
    oy_nxt = oy_r;
    sy_nxt = sy_r;
    dec1   = dec_r;
    if (dec_le) begin
      oy_nxt = oy_r + mcg_pkg::OFS_Y_BITS'(1);
      dec1   = dec_r + signed'(mcg_pkg::DEC_BITS'(sy_r));
      sy_nxt = sy_r + mcg_pkg::STEP_BITS'(2);
    end
    dec1_gt = !dec1[mcg_pkg::DEC_BITS-1] && (dec1 != '0);
    ox_nxt  = ox_r;
    sx_nxt  = sx_r;
    dec_nxt = dec1;
    if (dec1_gt) begin
      ox_nxt  = ox_r - mcg_pkg::OFS_X_BITS'(1);
      sx_nxt  = sx_r + mcg_pkg::STEP_BITS'(2);
      dec_nxt = dec1 + signed'(mcg_pkg::DEC_BITS'(sx_nxt))
              - signed'(mcg_pkg::DEC_BITS'(diam_r));
    end
    last_nxt = ox_nxt < signed'({1'b0, oy_nxt});

    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (step && last_nxt) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx_r   <= pop_data.cx;
      cy_r   <= pop_data.cy;
      diam_r <= pop_data.diam;
      ox_r   <= signed'(pop_data.ox0);
      oy_r   <= '0;
      sx_r   <= mcg_pkg::STEP_BITS'(1);
      sy_r   <= mcg_pkg::STEP_BITS'(1);
      dec_r  <= signed'(pop_data.dec0);
    end else if (step) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      dec_r <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      xr_r   <= cx_e + ox_e;
      xl_r   <= cx_e - ox_e;
      yd_r   <= cy_e + oy_e;
      yu_r   <= cy_e - oy_e;
      xrs_r  <= cx_e + oy_e;
      xls_r  <= cx_e - oy_e;
      yds_r  <= cy_e + ox_e;
      yus_r  <= cy_e - ox_e;
      last_r <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x_right         = xr_r;
  assign out_x_left          = xl_r;
  assign out_y_down          = yd_r;
  assign out_y_up            = yu_r;
  assign out_x_right_swapped = xrs_r;
  assign out_x_left_swapped  = xls_r;
  assign out_y_down_swapped  = yds_r;
  assign out_y_up_swapped    = yus_r;
  assign out_last            = last_r;

  a_loop_invariant: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (ox_r >= signed'({1'b0, oy_r})))
    else $error("loop running with x offset below y offset");

  a_steps_odd: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (sx_r[0] && sy_r[0]))
    else $error("step increments lost their odd parity");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_nxt) |=> (!busy_r && out_valid_r && out_last))
    else $error("final result did not end the circle");

endmodule

[design/midpoint_circle_generator_unit.sv]
// Results: a circle of radius r gives about r/sqrt(2)+1 results, one per cycle while
// the receiver takes them, once the request has passed the front stage and the queue
// and been loaded into the tracing loop; the single tracing loop in the back sets
// this rate. A zero-radius request is taken by the front and gives no result.
// Reset (rst_n low, synchronous) empties the front stage, the queue, the tracing loop
// and the result register; no memory needs clearing.
module midpoint_circle_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mcg_pkg::COORD_BITS-1:0]        in_centre_x,
  input  logic [mcg_pkg::COORD_BITS-1:0]        in_centre_y,
  input  logic [mcg_pkg::RADIUS_BITS-1:0]       in_radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_x_right,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_x_left,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_y_down,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_y_up,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_x_right_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_x_left_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_y_down_swapped,
  output logic signed [mcg_pkg::OUT_BITS-1:0]  out_y_up_swapped,
  output logic                                 out_last
);

  // The front takes each request transaction, works out the diameter, the first
  // x offset and the first decision value, and drops zero-radius requests.
  logic          fq_valid;
  logic          fq_ready;
  mcg_pkg::job_t fq_data;

  // The queue lets the front keep taking requests while the back traces a circle.
  logic          qb_valid;
  logic          qb_ready;
  mcg_pkg::job_t qb_data;

  mcg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_centre_x (in_centre_x),
    .in_centre_y (in_centre_y),
    .in_radius   (in_radius),
    .push_valid  (fq_valid),
    .push_ready  (fq_ready),
    .push_data   (fq_data)
  );

  mcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // The back runs the midpoint loop, one step per result transaction, and
  // holds each result in an output register until it is taken.
  mcg_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (qb_valid),
    .pop_ready           (qb_ready),
    .pop_data            (qb_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_x_right         (out_x_right),
    .out_x_left          (out_x_left),
    .out_y_down          (out_y_down),
    .out_y_up            (out_y_up),
    .out_x_right_swapped (out_x_right_swapped),
    .out_x_left_swapped  (out_x_left_swapped),
    .out_y_down_swapped  (out_y_down_swapped),
    .out_y_up_swapped    (out_y_up_swapped),
    .out_last            (out_last)
  );

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcg_pkg::*;

  // Cycles to let pass after the last result before the verdict. This leaves
  // margin for a stray result that should never come.
  localparam int SETTLE_CYCLES = 12;

  // Longest run of cycles without any transaction on either channel that the
  // watchdog allows. It lies well above the sender's longest gap, and the
  // receiver never stalls for long, so this is several times the worst case.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int RANDOM_CIRCLES = 330;

  // trace_circle gives up after this many steps per circle.
  localparam int STEP_LIMIT = 64;

  // One circle request as the sender queues it. When wait_idle is set, the
  // sender holds the request back until every expected result has arrived.
  typedef struct {
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] radius;
    bit                     wait_idle;
  } circle_req_t;

  // One expected result: the eight octant coordinates of a step and the
  // flag that closes a circle.
  typedef struct {
    logic signed [OUT_BITS-1:0] x_right;
    logic signed [OUT_BITS-1:0] x_left;
    logic signed [OUT_BITS-1:0] y_down;
    logic signed [OUT_BITS-1:0] y_up;
    logic signed [OUT_BITS-1:0] x_right_swapped;
    logic signed [OUT_BITS-1:0] x_left_swapped;
    logic signed [OUT_BITS-1:0] y_down_swapped;
    logic signed [OUT_BITS-1:0] y_up_swapped;
    logic                       last;
  } octant_set_t;

  // Ways the receiver applies backpressure; each lasts for a random stretch.
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_TRICKLE
  } sink_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [COORD_BITS-1:0]      in_centre_x = '0;
  logic [COORD_BITS-1:0]      in_centre_y = '0;
  logic [RADIUS_BITS-1:0]     in_radius = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] out_x_right;
  logic signed [OUT_BITS-1:0] out_x_left;
  logic signed [OUT_BITS-1:0] out_y_down;
  logic signed [OUT_BITS-1:0] out_y_up;
  logic signed [OUT_BITS-1:0] out_x_right_swapped;
  logic signed [OUT_BITS-1:0] out_x_left_swapped;
  logic signed [OUT_BITS-1:0] out_y_down_swapped;
  logic signed [OUT_BITS-1:0] out_y_up_swapped;
  logic                       out_last;

  midpoint_circle_generator_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_centre_x         (in_centre_x),
    .in_centre_y         (in_centre_y),
    .in_radius           (in_radius),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_x_right         (out_x_right),
    .out_x_left          (out_x_left),
    .out_y_down          (out_y_down),
    .out_y_up            (out_y_up),
    .out_x_right_swapped (out_x_right_swapped),
    .out_x_left_swapped  (out_x_left_swapped),
    .out_y_down_swapped  (out_y_down_swapped),
    .out_y_up_swapped    (out_y_up_swapped),
    .out_last            (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Requests waiting to be driven, and results the block still owes us.
  circle_req_t pending_circles[$];
  octant_set_t expected_octants[$];

  int total_circles = 0;
  int accepted_circles = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Our own copy of the tracer state. It starts idle, and the values are
  // left as the last loop step leaves them.
  int trc_ox = 0;
  int trc_oy = 0;
  int trc_sx = 1;
  int trc_sy = 1;
  int trc_dec = 0;
  int trc_diam = 0;
  int trc_cx = 0;
  int trc_cy = 0;
  bit trc_busy = 1'b0;

  // Coordinates are sent as 14 bit two's complement, never clipped, so a
  // sum that leaves the field simply wraps.
  function automatic logic signed [OUT_BITS-1:0] wrap_coord(input int v);
    return v[OUT_BITS-1:0];
  endfunction

  // Traces a whole circle the way the midpoint loop does and queues one
  // expected result per loop step. A zero radius starts offset_x at -1, so
  // the loop never runs and nothing is queued.
  function automatic void trace_circle(input logic [COORD_BITS-1:0] cx,
                                       input logic [COORD_BITS-1:0] cy,
                                       input logic [RADIUS_BITS-1:0] radius);
    int r;
    int steps;
    octant_set_t res;
    r = int'(radius);
    if (r > MAX_RADIUS) begin
      r = MAX_RADIUS;
    end
    trc_cx = int'(cx);
    trc_cy = int'(cy);
    trc_diam = 2 * r;
    trc_ox = r - 1;
    trc_oy = 0;
    trc_sx = 1;
    trc_sy = 1;
    trc_dec = 1 - trc_diam;
    trc_busy = 1'b1;
    steps = 0;
    while (trc_busy && trc_ox >= trc_oy && steps < STEP_LIMIT) begin
      res.x_right         = wrap_coord(trc_cx + trc_ox);
      res.x_left          = wrap_coord(trc_cx - trc_ox);
      res.y_down          = wrap_coord(trc_cy + trc_oy);
      res.y_up            = wrap_coord(trc_cy - trc_oy);
      res.x_right_swapped = wrap_coord(trc_cx + trc_oy);
      res.x_left_swapped  = wrap_coord(trc_cx - trc_oy);
      res.y_down_swapped  = wrap_coord(trc_cy + trc_ox);
      res.y_up_swapped    = wrap_coord(trc_cy - trc_ox);
      // Step along y first; the x step then looks at the updated decision.
      if (trc_dec <= 0) begin
        trc_oy += 1;
        trc_dec += trc_sy;
        trc_sy += 2;
      end
      if (trc_dec > 0) begin
        trc_ox -= 1;
        trc_sx += 2;
        trc_dec += trc_sx - trc_diam;
      end
      steps++;
      if (trc_ox < trc_oy || steps >= STEP_LIMIT) begin
        trc_busy = 1'b0;
      end
      res.last = !trc_busy;
      expected_octants.push_back(res);
    end
    trc_busy = 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name,
                             input logic signed [OUT_BITS-1:0] got,
                             input logic signed [OUT_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  task automatic add_circle(input int cx, input int cy, input int radius,
                            input bit wait_idle);
    circle_req_t req;
    req.cx = cx[COORD_BITS-1:0];
    req.cy = cy[COORD_BITS-1:0];
    req.radius = radius[RADIUS_BITS-1:0];
    req.wait_idle = wait_idle;
    pending_circles.push_back(req);
    total_circles++;
  endtask

  // The sender. It works in bursts of random length separated by random
  // gaps. A request is taken at an edge where in_valid and in_ready are both
  // high; until then valid and payload are left alone. Every signal gets one
  // nonblocking assignment per edge at most, so valid never dips between two
  // back-to-back transactions.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : circle_sender
    circle_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // The prediction is made on the payload that was just accepted.
      if (in_valid && in_ready) begin
        trace_circle(in_centre_x, in_centre_y, in_radius);
        accepted_circles++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_circles.size() == 0 ||
                     (pending_circles[0].wait_idle && expected_octants.size() != 0)) begin
          // Either nothing is left to send, or the next request wants the
          // block drained of every owed result first.
          in_valid <= 1'b0;
        end else begin
          nxt = pending_circles.pop_front();
          in_centre_x <= nxt.cx;
          in_centre_y <= nxt.cy;
          in_radius   <= nxt.radius;
          in_valid    <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Pick the next burst and the gap that follows it. A share of
            // gaps is zero, which gives long stretches with no idling; a few
            // are long enough to let the tracer run dry.
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(20, 80);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end
      end
    end
  end

  // The receiver. It switches between backpressure patterns of its own:
  // always ready, a coin toss, a fixed period, and a slow trickle.
  sink_mode_e sink_mode = SINK_OPEN;
  int sink_left = 0;
  int sink_phase = 0;

  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_left = $urandom_range(10, 60);
        sink_phase = 0;
      end else begin
        sink_left--;
        sink_phase++;
      end
      case (sink_mode)
        SINK_OPEN:     out_ready <= 1'b1;
        SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: out_ready <= (sink_phase % 3) != 2;
        default:       out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // The monitor. Every result transaction is matched against the oldest
  // expectation, field by field. A result with nothing owed is a failure.
  always @(posedge clk) begin : octant_monitor
    octant_set_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_octants.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (x_right %0d)",
                                  results_seen, out_x_right));
      end else begin
        want = expected_octants.pop_front();
        check_field("x_right", out_x_right, want.x_right);
        check_field("x_left", out_x_left, want.x_left);
        check_field("y_down", out_y_down, want.y_down);
        check_field("y_up", out_y_up, want.y_up);
        check_field("x_right_swapped", out_x_right_swapped, want.x_right_swapped);
        check_field("x_left_swapped", out_x_left_swapped, want.x_left_swapped);
        check_field("y_down_swapped", out_y_down_swapped, want.y_down_swapped);
        check_field("y_up_swapped", out_y_up_swapped, want.y_up_swapped);
        check_field("last", OUT_BITS'(out_last), OUT_BITS'(want.last));
      end
      results_seen++;
    end
  end

  // The watchdog. A stuck handshake on either side ends the run.
  always @(posedge clk) begin : stall_watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int cx;
    int cy;
    int radius;

    // Directed circles. A zero radius draws nothing, on its own and back to
    // back. The smallest circles give a single step. The largest radius at
    // the corners of the centre range sends coordinates below zero and past
    // 4095. Alternating bit patterns toggle every input bit.
    add_circle(2048, 2048, 0, 1'b0);
    add_circle(0, 0, 1, 1'b0);
    add_circle(4095, 4095, 1, 1'b0);
    add_circle(100, 200, 2, 1'b0);
    add_circle(300, 400, 3, 1'b0);
    add_circle(0, 0, 63, 1'b0);
    add_circle(4095, 4095, 63, 1'b0);
    add_circle(0, 4095, 63, 1'b0);
    add_circle(4095, 0, 63, 1'b0);
    add_circle(4095, 4095, 0, 1'b0);
    add_circle(0, 0, 0, 1'b0);
    add_circle(2730, 1365, 42, 1'b0);
    add_circle(1365, 2730, 21, 1'b0);
    add_circle(10, 20, 5, 1'b1);
    add_circle(62, 4033, 62, 1'b0);
    add_circle(2048, 2048, 0, 1'b1);
    add_circle(1000, 3000, 32, 1'b0);

    // Random circles. Most radii cover the whole range, a share is small so
    // circles change over quickly, and a few are zero. Some centres sit near
    // the edges so that coordinates cross zero or the top of the range.
    repeat (RANDOM_CIRCLES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: radius = $urandom_range(1, 8);
        3:       radius = 0;
        default: radius = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 7))
        0: begin
          cx = $urandom_range(0, 63);
          cy = $urandom_range(4032, 4095);
        end
        1: begin
          cx = $urandom_range(4032, 4095);
          cy = $urandom_range(0, 63);
        end
        default: begin
          cx = $urandom_range(0, 4095);
          cy = $urandom_range(0, 4095);
        end
      endcase
      add_circle(cx, cy, radius, $urandom_range(0, 39) == 0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, then for every owed result.
    while (accepted_circles < total_circles) @(posedge clk);
    while (expected_octants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_octants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
design/mcg_pkg.sv
design/mcg_front.sv
design/mcg_queue.sv
design/mcg_back.sv
design/midpoint_circle_generator_unit.sv
tb/testbench.sv
